// File: rtl/por_pkg.sv
// ----------------------------------------------------------------------------
// por_pkg: shared types and constants for the piecewise offset remapper
// Holds the command codes, the field widths and the layout of one stored rule.
// ----------------------------------------------------------------------------
`default_nettype none

package por_pkg;

  localparam int VAL_W         = 64;
  localparam int CMD_W         = 2;
  localparam int IDX_IN_W      = 4;
  localparam int CFG_W         = 5;
  localparam int MAX_RULES_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] start;
    logic [VAL_W-1:0] offset;
    logic [VAL_W-1:0] period;
    logic             both_sides;
  } rule_t;

endpackage

`default_nettype wire

// File: rtl/por_ram.sv
// ----------------------------------------------------------------------------
// por_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module por_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/piecewise_offset_remap.sv
// ----------------------------------------------------------------------------
// piecewise_offset_remap: applies or removes a table of piecewise offset rules
// Sequencer over a rule RAM, one shared restoring divider and one 32x32
// multiplier used three times per dividing rule.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per command. A write word (cmd 0) stores one rule and
//           gives no result. An apply (1) or remove (2) word remaps in_value_in
//           and gives one out_value_out word. Unused cmd 3 is dropped.
//   cfg_* : writes rule_count (clamped to MAX_RULES). Write only while idle.
//   in_ready is high only while the sequencer is idle. A write word leaves
//   the sequencer idle. A value word steps through every rule in use:
//   read, load, add for a skipped or period-zero rule, and read, load,
//   64 one-bit divider steps, 3 multiply passes, add for a dividing rule.
//   The divider loop sets the rate.
//   The result sits in an output register; the next word is accepted while
//   it waits. If a new result finishes while the old one is still not taken,
//   the sequencer holds until out_ready frees the register.
//   Reset clears rule_count and the control state; the rule RAM holds
//   garbage until each entry is written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_offset_remap #(
  parameter int MAX_RULES = por_pkg::MAX_RULES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [por_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [por_pkg::IDX_IN_W-1:0]   in_rule_index,
  input  wire logic [por_pkg::VAL_W-1:0]      in_rule_start,
  input  wire logic [por_pkg::VAL_W-1:0]      in_rule_step_offset,
  input  wire logic [por_pkg::VAL_W-1:0]      in_rule_period,
  input  wire logic                           in_rule_both_sides,
  input  wire logic [por_pkg::VAL_W-1:0]      in_value_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [por_pkg::VAL_W-1:0]      out_value_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [por_pkg::CFG_W-1:0]      cfg_rule_count
);

  localparam int VW    = por_pkg::VAL_W;
  localparam int HW    = VW / 2;
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int DC_W  = $clog2(VW);
  localparam int RW    = $bits(por_pkg::rule_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             rm_r, rm_nxt;
  logic [VW-1:0]    val_r, val_nxt;
  logic [VW-1:0]    dvd_r, dvd_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic             qneg_r, qneg_nxt;
  logic [DC_W-1:0]  dcnt_r, dcnt_nxt;
  logic [1:0]       mstep_r, mstep_nxt;
  logic [VW-1:0]    acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_value_r, out_value_nxt;

  por_pkg::rule_t   wr_rule, rd_rule;
  logic [RW-1:0]    rd_bits;
  logic             ram_we;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] rev_idx;
  logic             in_acc;
  logic             last_rule;

  // divider step
  logic [VW:0]      shl;
  logic [VW:0]      trial;
  logic             qbit;
  logic [VW-1:0]    quot;

  // multiplier
  logic [HW-1:0]    mul_a, mul_b;
  logic [VW-1:0]    prod;

  // rule evaluation
  logic [VW-1:0]    diff;
  logic             per_neg;
  logic             div_neg;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_value_out = out_value_r;

  assign wr_rule.start      = in_rule_start;
  assign wr_rule.offset     = in_rule_step_offset;
  assign wr_rule.period     = in_rule_period;
  assign wr_rule.both_sides = in_rule_both_sides;

  // drop writes beyond the table
  assign ram_we = in_acc && (in_cmd == por_pkg::CMD_WRITE) &&
                  (32'(in_rule_index) < MAX_RULES);

  // remove walks the table from the top down
  assign rev_idx   = n_r - j_r - CNT_W'(1);
  assign rd_addr   = rm_r ? rev_idx[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign last_rule = (j_r == n_r - CNT_W'(1));

  por_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_RULES),
    .AW    (IDX_W)
  ) u_rules (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (IDX_W'(in_rule_index)),
    .wdata   (wr_rule),
    .raddr   (rd_addr),
    .rdata_r (rd_bits)
  );

  assign rd_rule = por_pkg::rule_t'(rd_bits);

  assign diff    = val_r - rd_rule.start;
  assign per_neg = rd_rule.period[VW-1];
  // a negative period is negated unless both-sides is set; the most negative
  // period stays negative after negation
  assign div_neg = rd_rule.both_sides ? per_neg
                 : (per_neg && (rd_rule.period == {1'b1, {(VW-1){1'b0}}}));

  assign shl   = {rem_r, dvd_r[VW-1]};
  assign trial = shl - {1'b0, dvs_r};
  assign qbit  = !trial[VW];
  assign quot  = {dvd_r[VW-2:0], qbit};

  always_comb begin
    case (mstep_r)
      2'd0: begin
        mul_a = dvd_r[HW-1:0];
        mul_b = rd_rule.offset[HW-1:0];
      end
      2'd1: begin
        mul_a = dvd_r[HW-1:0];
        mul_b = rd_rule.offset[VW-1:HW];
      end
      default: begin
        mul_a = dvd_r[VW-1:HW];
        mul_b = rd_rule.offset[HW-1:0];
      end
    endcase
  end

  assign prod = VW'(mul_a) * VW'(mul_b);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    rm_nxt        = rm_r;
    val_nxt       = val_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    qneg_nxt      = qneg_r;
    dcnt_nxt      = dcnt_r;
    mstep_nxt     = mstep_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      n_nxt = (32'(cfg_rule_count) > MAX_RULES) ? CNT_W'(MAX_RULES)
                                                : CNT_W'(cfg_rule_count);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && ((in_cmd == por_pkg::CMD_APPLY) ||
                       (in_cmd == por_pkg::CMD_REMOVE))) begin
          val_nxt = in_value_in;
          rm_nxt  = (in_cmd == por_pkg::CMD_REMOVE);
          j_nxt   = '0;
          state_nxt = (n_r == '0) ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        // wait for the registered rule read
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (rd_rule.period == '0) begin
          if ($signed(rd_rule.start) < $signed(val_r)) begin
            val_nxt = rm_r ? (val_r - rd_rule.offset) : (val_r + rd_rule.offset);
          end
          state_nxt = S_ADD;
          acc_nxt   = '0;
        end else if (!rd_rule.both_sides &&
                     ((!per_neg && ($signed(val_r) < $signed(rd_rule.start))) ||
                      (per_neg && ($signed(rd_rule.start) < $signed(val_r))))) begin
          state_nxt = S_ADD;
          acc_nxt   = '0;
        end else begin
          dvd_nxt   = diff[VW-1] ? (VW'(0) - diff) : diff;
          dvs_nxt   = per_neg ? (VW'(0) - rd_rule.period) : rd_rule.period;
          rem_nxt   = '0;
          qneg_nxt  = diff[VW-1] ^ div_neg;
          dcnt_nxt  = DC_W'(VW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = qbit ? trial[VW-1:0] : shl[VW-1:0];
        dvd_nxt = quot;
        dcnt_nxt = dcnt_r - DC_W'(1);
        if (dcnt_r == '0) begin
          // fix the quotient sign and start the multiply passes
          dvd_nxt   = qneg_r ? (VW'(0) - quot) : quot;
          mstep_nxt = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd0) begin
          acc_nxt = prod;
        end else begin
          acc_nxt = acc_r + {prod[HW-1:0], {HW{1'b0}}};
        end
        if (mstep_r == 2'd2) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        val_nxt = rm_r ? (val_r - acc_r) : (val_r + acc_r);
        if (last_rule) begin
          state_nxt = S_FIN;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      j_r         <= '0;
      rm_r        <= 1'b0;
      dcnt_r      <= '0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      j_r         <= j_nxt;
      rm_r        <= rm_nxt;
      dcnt_r      <= dcnt_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    qneg_r      <= qneg_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for piecewise_offset_remap
// Loads the rule table, then runs apply, remove and rule-write words through a
// queue-fed driver under several rule counts. A monitor keeps its own copy of
// the table and checks every result word in order against its prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NRULES     = por_pkg::MAX_RULES_DEF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam longint      CYCLE_CAP  = 5000000;
  localparam int          DRAIN_WAIT = 1500;
  localparam logic [63:0] MIN64      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64      = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  idx;
    logic [63:0] start;
    logic [63:0] offset;
    logic [63:0] period;
    logic        both;
    logic [63:0] value;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [3:0]  in_rule_index = '0;
  logic [63:0] in_rule_start = '0;
  logic [63:0] in_rule_step_offset = '0;
  logic [63:0] in_rule_period = '0;
  logic        in_rule_both_sides = 1'b0;
  logic [63:0] in_value_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_rule_count = '0;

  piecewise_offset_remap uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_rule_index       (in_rule_index),
    .in_rule_start       (in_rule_start),
    .in_rule_step_offset (in_rule_step_offset),
    .in_rule_period      (in_rule_period),
    .in_rule_both_sides  (in_rule_both_sides),
    .in_value_in         (in_value_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_value_out       (out_value_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_rule_count      (cfg_rule_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words waiting for the driver, and remapped values waiting for the block.
  word_t       pending_words[$];
  logic [63:0] remap_expected[$];

  // Shadow of the block: rule table and rule count.
  logic [63:0] shadow_start  [NRULES];
  logic [63:0] shadow_offset [NRULES];
  logic [63:0] shadow_period [NRULES];
  logic        shadow_both   [NRULES];
  logic [4:0]  shadow_count = '0;

  int     errors = 0;
  int     results_seen = 0;
  int     values_sent = 0;
  int     writes_sent = 0;
  longint cycles = 0;
  bit     quiet_phase = 1'b0;   // no idling on either side while set
  bit     in_fire = 1'b0;
  bit     cfg_fire = 1'b0;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  // Operand mix: corner values, small numbers and full random patterns.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN64;
      1: return MAX64;
      2: return 64'd0;
      3: return {64{1'b1}};
      4, 5: return 64'($signed($urandom_range(0, 400)) - 200);
      6: return 64'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] step_rule(logic [63:0] v, int i, bit rem);
    logic [63:0] s;
    logic [63:0] o;
    logic [63:0] p;
    logic [63:0] delta;
    s = shadow_start[i];
    o = shadow_offset[i];
    p = shadow_period[i];
    if (p == 64'd0) begin
      if ($signed(v) > $signed(s)) v = rem ? v - o : v + o;
      return v;
    end
    if (!shadow_both[i]) begin
      if (!p[63]) begin
        if ($signed(v) < $signed(s)) return v;
      end else begin
        if ($signed(v) > $signed(s)) return v;
        p = -p;   // most negative period wraps and stays as it is
      end
    end
    delta = signed_quotient(v - s, p) * o;
    return rem ? v - delta : v + delta;
  endfunction

  function automatic logic [63:0] remap_value(logic [1:0] cmd, logic [63:0] v);
    int n;
    n = (shadow_count > NRULES) ? NRULES : int'(shadow_count);
    if (cmd == por_pkg::CMD_APPLY) begin
      for (int k = 0; k < n; k++) v = step_rule(v, k, 1'b0);
    end else begin
      for (int k = n - 1; k >= 0; k--) v = step_rule(v, k, 1'b1);
    end
    return v;
  endfunction

  // Driver: hold the word until accepted, then advance after a random gap.
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_cmd <= w.cmd;
        in_rule_index <= w.idx;
        in_rule_start <= w.start;
        in_rule_step_offset <= w.offset;
        in_rule_period <= w.period;
        in_rule_both_sides <= w.both;
        in_value_in <= w.value;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: stall in bursts of random length.
  int out_stall = 0;
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // Monitor: predict on accepted words, check accepted results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow_count = cfg_rule_count;
      if (in_valid && in_ready) begin
        case (in_cmd)
          por_pkg::CMD_WRITE: begin
            shadow_start[in_rule_index] = in_rule_start;
            shadow_offset[in_rule_index] = in_rule_step_offset;
            shadow_period[in_rule_index] = in_rule_period;
            shadow_both[in_rule_index] = in_rule_both_sides;
          end
          por_pkg::CMD_APPLY, por_pkg::CMD_REMOVE:
            remap_expected.push_back(remap_value(in_cmd, in_value_in));
          default: ;  // unused command: drop
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (remap_expected.size() == 0) begin
          $error("value_out: no result expected, got %h", out_value_out);
          errors++;
        end else begin
          logic [63:0] want;
          want = remap_expected.pop_front();
          if (out_value_out !== want) begin
            $error("value_out: expected %h, got %h", want, out_value_out);
            errors++;
          end
        end
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] cmd, logic [3:0] idx, logic [63:0] s,
                           logic [63:0] o, logic [63:0] p, logic b, logic [63:0] v);
    word_t w;
    w.cmd = cmd; w.idx = idx; w.start = s; w.offset = o;
    w.period = p; w.both = b; w.value = v;
    pending_words.push_back(w);
    if (cmd == por_pkg::CMD_WRITE) writes_sent++;
    else if (cmd != CMD_UNUSED) values_sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() > 0 || in_valid || remap_expected.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Write the rule count only when the block is idle.
  task automatic set_rule_count(logic [4:0] n);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_rule_count <= n;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // Random word: mostly values near a rule start, some writes, a little noise.
  task automatic push_random();
    int r;
    int i;
    logic [63:0] p;
    r = $urandom_range(0, 99);
    i = $urandom_range(0, NRULES - 1);
    if (r < 3) begin
      push_word(CMD_UNUSED, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, 1'($urandom), {$urandom, $urandom});
    end else if (r < 30) begin
      case ($urandom_range(0, 5))
        0: p = 64'd0;
        1: p = MIN64;
        2: p = pick_operand();
        default: p = 64'($signed($urandom_range(0, 40)) - 20);
      endcase
      push_word(por_pkg::CMD_WRITE, 4'(i), pick_operand(), pick_operand(), p,
                1'($urandom), {$urandom, $urandom});
    end else begin
      logic [63:0] v;
      if ($urandom_range(0, 3) == 0) v = pick_operand();
      else v = shadow_start[i] + 64'($signed($urandom_range(0, 200)) - 100);
      push_word($urandom_range(0, 1) ? por_pkg::CMD_APPLY : por_pkg::CMD_REMOVE,
                4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, 1'($urandom), v);
    end
  endtask

  initial begin
    logic [4:0] counts[8];
    counts = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd2, 5'd16};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // No rules in use yet: values pass through, unused command is dropped.
    push_word(por_pkg::CMD_APPLY, '0, '0, '0, '0, 1'b0, MIN64);
    push_word(por_pkg::CMD_REMOVE, '0, '0, '0, '0, 1'b0, MAX64);
    push_word(CMD_UNUSED, 4'hf, MAX64, MAX64, MAX64, 1'b1, MAX64);
    // Fill the whole table: single step, wrapped negative period, division
    // overflow, positive and negative periods on one and both sides.
    push_word(por_pkg::CMD_WRITE, 4'd0, 64'd0, 64'd3, {64{1'b1}}, 1'b1, '0);
    push_word(por_pkg::CMD_WRITE, 4'd1, 64'd10, MAX64, 64'd0, 1'b0, '0);
    push_word(por_pkg::CMD_WRITE, 4'd2, MIN64, 64'd1, MIN64, 1'b0, '0);
    push_word(por_pkg::CMD_WRITE, 4'd3, MAX64, MIN64, MIN64, 1'b1, '0);
    push_word(por_pkg::CMD_WRITE, 4'd4, 64'd5, 64'd7, -64'd4, 1'b0, '0);
    push_word(por_pkg::CMD_WRITE, 4'd5, -64'd5, -64'd2, 64'd3, 1'b0, '0);
    push_word(por_pkg::CMD_WRITE, 4'd6, 64'd0, 64'd1, MAX64, 1'b1, '0);
    push_word(por_pkg::CMD_WRITE, 4'd7, 64'd100, 64'd9, -64'd7, 1'b1, '0);
    for (int i = 8; i < NRULES; i++)
      push_word(por_pkg::CMD_WRITE, 4'(i), pick_operand(), pick_operand(),
                64'($signed($urandom_range(0, 20)) - 10), 1'($urandom), '0);

    set_rule_count(5'd16);
    push_word(por_pkg::CMD_APPLY, '0, '0, '0, '0, 1'b0, MIN64);
    push_word(por_pkg::CMD_REMOVE, '0, '0, '0, '0, 1'b0, MIN64);
    push_word(por_pkg::CMD_APPLY, '0, '0, '0, '0, 1'b0, MAX64);
    push_word(por_pkg::CMD_REMOVE, '0, '0, '0, '0, 1'b0, MAX64);
    push_word(por_pkg::CMD_APPLY, '0, '0, '0, '0, 1'b0, 64'd0);
    push_word(por_pkg::CMD_REMOVE, '0, '0, '0, '0, 1'b0, 64'd11);
    set_rule_count(5'd1);
    push_word(por_pkg::CMD_APPLY, '0, '0, '0, '0, 1'b0, MIN64);   // min / -1 wraps
    push_word(por_pkg::CMD_REMOVE, '0, '0, '0, '0, 1'b0, MIN64);

    // Random phases over a spread of counts, every other one without idling.
    for (int ph = 0; ph < 8; ph++) begin
      quiet_phase = ph[0];
      set_rule_count(counts[ph]);
      for (int k = 0; k < 64; k++) push_random();
    end

    wait_drained();
    $display("Covered %0d value words and %0d rule writes, %0d results checked,",
             values_sent, writes_sent, results_seen);
    $display("rule counts 0 to 31 with clamping, under random stalls on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
